FILE: rtl/uart_receiver_with_rx_fifo_macros.svh
// Assertion helpers for the checker of the UART receiver.
`ifndef UART_RECEIVER_WITH_RX_FIFO_MACROS_SVH
`define UART_RECEIVER_WITH_RX_FIFO_MACROS_SVH

// Clocked assertion, quiet while reset is high.
`define UARTRX_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also checks during reset.
`define UARTRX_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/uartrx_pkg.sv
package uartrx_pkg;

   localparam int FIFO_DEPTH_DEFAULT = 64;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;
   localparam int DELAY_W     = 16;
   localparam int BYTE_W      = 8;
   localparam int FILL_W      = 6;
   localparam int BIT_IDX_W   = 3;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_RX_ENABLE    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CENTER_DELAY = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BIT_DELAY    = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_STOP_DELAY   = 2'd3;

   // Register reset values
   localparam logic [DELAY_W-1:0] CENTER_DELAY_RESET = 16'd184;
   localparam logic [DELAY_W-1:0] BIT_DELAY_RESET    = 16'd208;
   localparam logic [DELAY_W-1:0] STOP_DELAY_RESET   = 16'd208;

   localparam logic [BIT_IDX_W-1:0] LAST_DATA_BIT = 3'd7;

   typedef struct packed {
      logic rx_level;
      logic read_request;
   } req_type;

   typedef struct packed {
      logic [BYTE_W-1:0] read_data;
      logic              read_valid;
      logic [FILL_W-1:0] fill_count;
      logic              overflow_flag;
      logic              frame_busy;
   } rsp_type;

   typedef struct packed {
      logic               rx_enable;
      logic [DELAY_W-1:0] center_delay_ticks;
      logic [DELAY_W-1:0] bit_delay_ticks;
      logic [DELAY_W-1:0] stop_delay_ticks;
   } cfg_type;

   // Work handed from the deframer to the FIFO side, one per tick.
   typedef struct packed {
      logic              read_request;
      logic              store_valid;
      logic [BYTE_W-1:0] store_byte;
      logic              frame_busy;
   } cmd_type;

   // A zero delay counts as one tick.
   function automatic logic [DELAY_W-1:0] at_least_one(input logic [DELAY_W-1:0] v);
      return (v == '0) ? DELAY_W'(1) : v;
   endfunction

endpackage

FILE: rtl/uartrx_ram.sv
module uartrx_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/uartrx_front.sv
module uartrx_front (
   input  logic                clock,
   input  logic                reset,
   input  uartrx_pkg::cfg_type cfg,
   input  logic                req_valid,
   input  uartrx_pkg::req_type req_payload,
   input  logic                queue_full,
   output logic                cmd_push,
   output uartrx_pkg::cmd_type cmd
);
   import uartrx_pkg::*;

   typedef enum logic [3:0] {
      PH_IDLE   = 4'b0001,
      PH_CENTER = 4'b0010,
      PH_DATA   = 4'b0100,
      PH_STOP   = 4'b1000
   } phase_type;

   phase_type            phase_ff, phase_in;
   logic [DELAY_W-1:0]   cnt_ff, cnt_in, cnt_dec;
   logic [BIT_IDX_W-1:0] bit_idx_ff, bit_idx_in;
   logic [BYTE_W-1:0]    shift_ff, shift_in;
   logic                 prev_level_ff;
   logic                 accept, tick_done, store_valid;

   assign accept    = req_valid && !queue_full;
   assign cnt_dec   = cnt_ff - DELAY_W'(1);
   assign tick_done = (cnt_dec == '0);

   always_comb begin
      phase_in    = phase_ff;
      cnt_in      = cnt_ff;
      bit_idx_in  = bit_idx_ff;
      shift_in    = shift_ff;
      store_valid = 1'b0;
      unique case (phase_ff)
         PH_IDLE: begin
            // Falling edge arms a frame.
            if (cfg.rx_enable && prev_level_ff && !req_payload.rx_level) begin
               phase_in   = PH_CENTER;
               cnt_in     = at_least_one(cfg.center_delay_ticks);
               bit_idx_in = '0;
               shift_in   = '0;
            end
         end
         PH_CENTER: begin
            cnt_in = cnt_dec;
            if (tick_done) begin
               phase_in = PH_DATA;
               cnt_in   = at_least_one(cfg.bit_delay_ticks);
            end
         end
         PH_DATA: begin
            cnt_in = cnt_dec;
            if (tick_done) begin
               shift_in = {req_payload.rx_level, shift_ff[BYTE_W-1:1]};
               if (bit_idx_ff == LAST_DATA_BIT) begin
                  bit_idx_in  = '0;
                  store_valid = 1'b1;
                  phase_in    = PH_STOP;
                  cnt_in      = at_least_one(cfg.stop_delay_ticks);
               end else begin
                  bit_idx_in = bit_idx_ff + BIT_IDX_W'(1);
                  cnt_in     = at_least_one(cfg.bit_delay_ticks);
               end
            end
         end
         PH_STOP: begin
            cnt_in = cnt_dec;
            if (tick_done) begin
               phase_in = PH_IDLE;
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         cnt_ff        <= '0;
         bit_idx_ff    <= '0;
         shift_ff      <= '0;
         prev_level_ff <= 1'b1;
      end else if (accept) begin
         phase_ff      <= phase_in;
         cnt_ff        <= cnt_in;
         bit_idx_ff    <= bit_idx_in;
         shift_ff      <= shift_in;
         prev_level_ff <= req_payload.rx_level;
      end
   end

   assign cmd_push          = accept;
   assign cmd.read_request  = req_payload.read_request;
   assign cmd.store_valid   = store_valid;
   assign cmd.store_byte    = shift_in;
   assign cmd.frame_busy    = (phase_in != PH_IDLE);

endmodule

FILE: rtl/uartrx_queue.sv
module uartrx_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  uartrx_pkg::cmd_type push_cmd,
   output logic                full,
   output logic                head_valid,
   output uartrx_pkg::cmd_type head_cmd,
   input  logic                pop
);
   import uartrx_pkg::*;

   cmd_type    entry_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;

   assign full       = (count_ff == 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head_cmd   = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         case ({push, pop})
            2'b10:   count_ff <= count_ff + 2'd1;
            2'b01:   count_ff <= count_ff - 2'd1;
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule

FILE: rtl/uartrx_back.sv
module uartrx_back #(
   parameter int FIFO_DEPTH = uartrx_pkg::FIFO_DEPTH_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                rx_enable,
   input  logic                cmd_valid,
   input  uartrx_pkg::cmd_type cmd,
   output logic                cmd_pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output uartrx_pkg::rsp_type rsp_payload
);
   import uartrx_pkg::*;

   localparam int AW = $clog2(FIFO_DEPTH);
   localparam int CW = (AW + 1 > FILL_W) ? AW + 1 : FILL_W;

   logic [AW-1:0]     head_ff, tail_ff, head_after, tail_next, tail_in;
   logic              ovf_ff, ovf_in;
   logic              fire, pop, space, wr;
   logic [CW-1:0]     fill_wide;
   logic [BYTE_W-1:0] ram_q;
   logic              rsp_valid_ff;
   logic              rvalid_ff, busy_ff, ovf_out_ff;
   logic [FILL_W-1:0] fill_ff;

   function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] idx);
      return (idx == AW'(FIFO_DEPTH - 1)) ? '0 : idx + AW'(1);
   endfunction

   // Take one command whenever the output register is free or being drained.
   assign fire    = cmd_valid && (!rsp_valid_ff || !rsp_stall);
   assign cmd_pop = fire;

   // Pop first, then store into the space that the pop may have freed.
   assign pop        = cmd.read_request && rx_enable && (head_ff != tail_ff);
   assign head_after = pop ? wrap_inc(head_ff) : head_ff;
   assign tail_next  = wrap_inc(tail_ff);
   assign space      = (tail_next != head_after);
   assign wr         = cmd.store_valid && space;
   assign tail_in    = wr ? tail_next : tail_ff;
   assign ovf_in     = ovf_ff || (cmd.store_valid && !space);

   always_comb begin
      if (tail_in >= head_after) begin
         fill_wide = CW'(tail_in) - CW'(head_after);
      end else begin
         fill_wide = CW'(tail_in) + CW'(FIFO_DEPTH) - CW'(head_after);
      end
   end

   uartrx_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (FIFO_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (fire && wr),
      .wr_addr (tail_ff),
      .wr_data (cmd.store_byte),
      .rd_en   (fire && pop),
      .rd_addr (head_ff),
      .rd_data (ram_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         tail_ff      <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (fire) begin
            head_ff      <= head_after;
            tail_ff      <= tail_in;
            ovf_ff       <= ovf_in;
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rvalid_ff  <= pop;
         fill_ff    <= fill_wide[FILL_W-1:0];
         ovf_out_ff <= ovf_in;
         busy_ff    <= cmd.frame_busy;
      end
   end

   assign rsp_valid                 = rsp_valid_ff;
   assign rsp_payload.read_data     = rvalid_ff ? ram_q : '0;
   assign rsp_payload.read_valid    = rvalid_ff;
   assign rsp_payload.fill_count    = fill_ff;
   assign rsp_payload.overflow_flag = ovf_out_ff;
   assign rsp_payload.frame_busy    = busy_ff;

endmodule

FILE: rtl/uart_receiver_with_rx_fifo.sv
// Channel    | Direction | Handshake            | Transaction
// -----------+-----------+----------------------+------------------------------------
// req_       | in        | req_valid/req_stall  | one line tick: rx_level, read_request
// rsp_       | out       | rsp_valid/rsp_stall  | one result per tick: byte, flags, fill
// csr_       | in        | csr_write            | register write, no wait
//
// One tick is taken every clock while req_stall is low; the deframer updates its
// state as each tick is accepted, and the tick is written into the command queue;
// when the back end takes it from there, the result register and the RAM's
// registered read port load together and the result becomes valid.
// Reset clears control state only; the RAM contents are left as they are.
// rsp_stall holds the output register, then fills the two-entry command queue,
// and only then raises req_stall.
module uart_receiver_with_rx_fifo #(
   parameter int FIFO_DEPTH = uartrx_pkg::FIFO_DEPTH_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  uartrx_pkg::req_type                   req_payload,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output uartrx_pkg::rsp_type                   rsp_payload,
   input  logic                                  csr_write,
   input  logic [uartrx_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [uartrx_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import uartrx_pkg::*;

   cfg_type cfg_ff;
   logic    push, queue_full, head_valid, pop;
   cmd_type push_cmd, head_cmd;

   // Config registers; user writes only while no transaction is in flight, unenforced.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rx_enable          <= 1'b0;
         cfg_ff.center_delay_ticks <= CENTER_DELAY_RESET;
         cfg_ff.bit_delay_ticks    <= BIT_DELAY_RESET;
         cfg_ff.stop_delay_ticks   <= STOP_DELAY_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_RX_ENABLE:    cfg_ff.rx_enable          <= csr_wdata[0];
            CSR_CENTER_DELAY: cfg_ff.center_delay_ticks <= csr_wdata[DELAY_W-1:0];
            CSR_BIT_DELAY:    cfg_ff.bit_delay_ticks    <= csr_wdata[DELAY_W-1:0];
            CSR_STOP_DELAY:   cfg_ff.stop_delay_ticks   <= csr_wdata[DELAY_W-1:0];
            default:          cfg_ff                    <= cfg_ff;
         endcase
      end
   end

   // Front: edge detect, bit timing and byte assembly.
   uartrx_front u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .req_valid   (req_valid),
      .req_payload (req_payload),
      .queue_full  (queue_full),
      .cmd_push    (push),
      .cmd         (push_cmd)
   );

   // Decouple the tick stream from the FIFO side.
   uartrx_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .pop        (pop)
   );

   // Back: ring FIFO, overflow flag and result register.
   uartrx_back #(
      .FIFO_DEPTH (FIFO_DEPTH)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .rx_enable   (cfg_ff.rx_enable),
      .cmd_valid   (head_valid),
      .cmd         (head_cmd),
      .cmd_pop     (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   assign req_stall = queue_full;

endmodule

FILE: rtl/uartrx_checker.sv
`include "uart_receiver_with_rx_fifo_macros.svh"

module uartrx_checker (
   input  logic                clock,
   input  logic                reset,
   input  logic                rsp_valid,
   input  logic                rsp_stall,
   input  uartrx_pkg::rsp_type rsp_payload
);
   import uartrx_pkg::*;

   `UARTRX_ASSERT(a_rsp_valid_holds, clock, reset, rsp_valid && rsp_stall |=> rsp_valid, "rsp_valid dropped while stalled")
   `UARTRX_ASSERT(a_rsp_payload_holds, clock, reset, rsp_valid && rsp_stall |=> $stable(rsp_payload), "rsp_payload changed while stalled")
   `UARTRX_ASSERT(a_no_data_without_pop, clock, reset, rsp_valid && !rsp_payload.read_valid |-> rsp_payload.read_data == '0, "read_data nonzero without a pop")
   `UARTRX_ASSERT(a_overflow_sticky, clock, reset, rsp_valid && !rsp_stall && rsp_payload.overflow_flag |=> !rsp_valid || rsp_payload.overflow_flag, "overflow flag cleared")
   `UARTRX_ASSERT_ALWAYS(a_reset_clears_rsp, clock, reset |=> !rsp_valid, "result pending right after reset")

endmodule

bind uart_receiver_with_rx_fifo uartrx_checker u_checker (.*);

FILE: dv/tb_top.sv
module tb_top;
   import uartrx_pkg::*;

   // Receiver phases, as the deframer walks through one frame.
   typedef enum logic [3:0] {
      RX_IDLE   = 4'b0001,
      RX_CENTER = 4'b0010,
      RX_DATA   = 4'b0100,
      RX_STOP   = 4'b1000
   } rx_phase_type;

   // One row of the directed table: a line tick or a register write.
   typedef enum logic {
      ROW_TICK,
      ROW_CSR
   } row_kind_type;

   typedef struct packed {
      row_kind_type             kind;
      logic [CSR_INDEX_W-1:0]   reg_idx;
      logic [CSR_DATA_W-1:0]    reg_data;
      req_type                  line;
      logic                     typed;
      rsp_type                  want;
   } stim_row_type;

   // Line offsets below count from the tick that carries the falling edge.
   // All delays sit at zero there, so each one acts as a single tick: the
   // center ends at offset 1, bits are sampled at offsets 2..9 and the stop
   // wait ends at offset 10.
   localparam int DIRECTED_ROWS = 32;
   localparam stim_row_type DIRECTED_STIM [DIRECTED_ROWS] = '{
      // out of reset, disabled: reads give nothing, a falling edge is ignored
      '{ROW_TICK, CSR_RX_ENABLE, 16'd0, '{1'b1, 1'b1}, 1'b1, '{8'h00, 1'b0, 6'd0, 1'b0, 1'b0}},
      '{ROW_TICK, CSR_RX_ENABLE, 16'd0, '{1'b0, 1'b1}, 1'b1, '{8'h00, 1'b0, 6'd0, 1'b0, 1'b0}},
      // enable, zero delays behave as one tick each
      '{ROW_CSR, CSR_RX_ENABLE, 16'd1, '{1'b1, 1'b0}, 1'b0, '0},
      '{ROW_CSR, CSR_CENTER_DELAY, 16'd0, '{1'b1, 1'b0}, 1'b0, '0},
      '{ROW_CSR, CSR_BIT_DELAY, 16'd0, '{1'b1, 1'b0}, 1'b0, '0},
      '{ROW_CSR, CSR_STOP_DELAY, 16'd0, '{1'b1, 1'b0}, 1'b0, '0},
      // read from an empty FIFO
      '{ROW_TICK, CSR_RX_ENABLE, 16'd0, '{1'b1, 1'b1}, 1'b1, '{8'h00, 1'b0, 6'd0, 1'b0, 1'b0}},
      // frame carrying 0xFF: start edge, center, eight ones, stop
      '{ROW_TICK, CSR_RX_ENABLE, 16'd0, '{1'b0, 1'b0}, 1'b1, '{8'h00, 1'b0, 6'd0, 1'b0, 1'b1}},
      '{ROW_TICK, CSR_RX_ENABLE, 16'd0, '{1'b0, 1'b0}, 1'b0, '0},
      '{ROW_TICK, CSR_RX_ENABLE, 16'd0, '{1'b1, 1'b0}, 1'b0, '0},
      '{ROW_TICK, CSR_RX_ENABLE, 16'd0, '{1'b1, 1'b0}, 1'b0, '0},
      '{ROW_TICK, CSR_RX_ENABLE, 16'd0, '{1'b1, 1'b0}, 1'b0, '0},
      '{ROW_TICK, CSR_RX_ENABLE, 16'd0, '{1'b1, 1'b0}, 1'b0, '0},
      '{ROW_TICK, CSR_RX_ENABLE, 16'd0, '{1'b1, 1'b0}, 1'b0, '0},
      '{ROW_TICK, CSR_RX_ENABLE, 16'd0, '{1'b1, 1'b0}, 1'b0, '0},
      '{ROW_TICK, CSR_RX_ENABLE, 16'd0, '{1'b1, 1'b0}, 1'b0, '0},
      '{ROW_TICK, CSR_RX_ENABLE, 16'd0, '{1'b1, 1'b0}, 1'b0, '0},
      // stop wait ends while the stored 0xFF is popped
      '{ROW_TICK, CSR_RX_ENABLE, 16'd0, '{1'b1, 1'b1}, 1'b1, '{8'hFF, 1'b1, 6'd0, 1'b0, 1'b0}},
      // next start edge
      '{ROW_TICK, CSR_RX_ENABLE, 16'd0, '{1'b0, 1'b0}, 1'b1, '{8'h00, 1'b0, 6'd0, 1'b0, 1'b1}},
      // disable mid-frame: the frame still completes and stores 0x00
      '{ROW_CSR, CSR_RX_ENABLE, 16'd0, '{1'b1, 1'b0}, 1'b0, '0},
      '{ROW_TICK, CSR_RX_ENABLE, 16'd0, '{1'b0, 1'b0}, 1'b0, '0},
      '{ROW_TICK, CSR_RX_ENABLE, 16'd0, '{1'b0, 1'b0}, 1'b0, '0},
      '{ROW_TICK, CSR_RX_ENABLE, 16'd0, '{1'b0, 1'b0}, 1'b0, '0},
      '{ROW_TICK, CSR_RX_ENABLE, 16'd0, '{1'b0, 1'b0}, 1'b0, '0},
      '{ROW_TICK, CSR_RX_ENABLE, 16'd0, '{1'b0, 1'b0}, 1'b0, '0},
      '{ROW_TICK, CSR_RX_ENABLE, 16'd0, '{1'b0, 1'b0}, 1'b0, '0},
      '{ROW_TICK, CSR_RX_ENABLE, 16'd0, '{1'b0, 1'b0}, 1'b0, '0},
      '{ROW_TICK, CSR_RX_ENABLE, 16'd0, '{1'b0, 1'b0}, 1'b0, '0},
      // last sample stores the byte; the read is refused while disabled
      '{ROW_TICK, CSR_RX_ENABLE, 16'd0, '{1'b0, 1'b1}, 1'b1, '{8'h00, 1'b0, 6'd1, 1'b0, 1'b1}},
      '{ROW_TICK, CSR_RX_ENABLE, 16'd0, '{1'b1, 1'b0}, 1'b1, '{8'h00, 1'b0, 6'd1, 1'b0, 1'b0}},
      // enable again and pop the stored 0x00
      '{ROW_CSR, CSR_RX_ENABLE, 16'd1, '{1'b1, 1'b0}, 1'b0, '0},
      '{ROW_TICK, CSR_RX_ENABLE, 16'd0, '{1'b1, 1'b1}, 1'b1, '{8'h00, 1'b1, 6'd0, 1'b0, 1'b0}}
   };

   // Line follows the frame at every offset up to this one.
   localparam int WHOLE_FRAME = 1 << 30;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   req_type                req_payload;
   logic                   rsp_valid;
   logic                   rsp_stall;
   rsp_type                rsp_payload;
   logic                   csr_write;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   // Receiver state as the testbench expects it, updated as each tick is accepted.
   cfg_type            cfg = '{1'b0, CENTER_DELAY_RESET, BIT_DELAY_RESET, STOP_DELAY_RESET};
   rx_phase_type       rx_phase = RX_IDLE;
   logic [DELAY_W-1:0] tick_cnt = '0;
   logic [3:0]         bits_taken = '0;
   logic [BYTE_W-1:0]  shreg = '0;
   logic               prev_level = 1'b1;
   logic [BYTE_W-1:0]  fifo_mem [FIFO_DEPTH_DEFAULT];
   logic [FILL_W-1:0]  fifo_head = '0;
   logic [FILL_W-1:0]  fifo_tail = '0;
   logic               byte_dropped = 1'b0;

   rsp_type pending_rx_results [$];
   rsp_type want_rsp;
   int      mismatch_count = 0;
   int      ticks_sent = 0;
   int      read_pct = 20;
   logic    idle_en = 1'b1;

   uart_receiver_with_rx_fifo dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_write   (csr_write),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Advance the expected receiver by one tick and return the result it owes.
   // The read port goes first, so a store in the same tick sees the freed slot.
   function automatic rsp_type advance_receiver(input req_type line);
      rsp_type           r;
      logic [FILL_W-1:0] next_tail;
      r = '0;
      if (line.read_request && cfg.rx_enable && fifo_head != fifo_tail) begin
         r.read_data  = fifo_mem[fifo_head];
         r.read_valid = 1'b1;
         fifo_head    = fifo_head + 1'b1;
      end
      case (rx_phase)
         RX_IDLE: begin
            // only a falling edge while enabled opens a frame
            if (cfg.rx_enable && prev_level && !line.rx_level) begin
               rx_phase   = RX_CENTER;
               tick_cnt   = (cfg.center_delay_ticks == 0) ? DELAY_W'(1)
                                                          : cfg.center_delay_ticks;
               bits_taken = '0;
               shreg      = '0;
            end
         end
         RX_CENTER: begin
            tick_cnt = tick_cnt - 1'b1;
            if (tick_cnt == 0) begin
               rx_phase = RX_DATA;
               tick_cnt = (cfg.bit_delay_ticks == 0) ? DELAY_W'(1) : cfg.bit_delay_ticks;
            end
         end
         RX_DATA: begin
            tick_cnt = tick_cnt - 1'b1;
            if (tick_cnt == 0) begin
               // shift in LSB first; the eighth sample completes the byte
               shreg      = {line.rx_level, shreg[BYTE_W-1:1]};
               bits_taken = bits_taken + 1'b1;
               if (bits_taken == BYTE_W) begin
                  bits_taken = '0;
                  next_tail  = fifo_tail + 1'b1;
                  if (next_tail != fifo_head) begin
                     fifo_mem[fifo_tail] = shreg;
                     fifo_tail           = next_tail;
                  end else begin
                     byte_dropped = 1'b1;
                  end
                  rx_phase = RX_STOP;
                  tick_cnt = (cfg.stop_delay_ticks == 0) ? DELAY_W'(1)
                                                         : cfg.stop_delay_ticks;
               end else begin
                  tick_cnt = (cfg.bit_delay_ticks == 0) ? DELAY_W'(1)
                                                        : cfg.bit_delay_ticks;
               end
            end
         end
         default: begin
            // stop bit is not checked, just waited out
            tick_cnt = tick_cnt - 1'b1;
            if (tick_cnt == 0) rx_phase = RX_IDLE;
         end
      endcase
      prev_level      = line.rx_level;
      r.fill_count    = fifo_tail - fifo_head;
      r.overflow_flag = byte_dropped;
      r.frame_busy    = (rx_phase != RX_IDLE);
      return r;
   endfunction

   // Mostly short gaps, now and then a long one.
   function automatic int gap_len();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 75) return $urandom_range(1, 3);
      if (roll < 95) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [DELAY_W-1:0] rand_delay();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 70) return DELAY_W'($urandom_range(0, 3));
      if (roll < 95) return DELAY_W'($urandom_range(4, 12));
      return DELAY_W'($urandom_range(13, 40));
   endfunction

   task automatic check_field(input string field, input logic [7:0] want,
                              input logic [7:0] got);
      if (got !== want) begin
         mismatch_count++;
         if (mismatch_count <= 200)
            $display("%0t: %s expected 0x%0h, got 0x%0h", $time, field, want, got);
      end
   endtask

   // Offer one tick, hold it until the block takes it, then log what it owes.
   task automatic send_tick(input req_type line, input logic typed, input rsp_type want);
      rsp_type predicted;
      if (idle_en && $urandom_range(0, 99) < 20) begin
         req_valid <= 1'b0;
         repeat (gap_len()) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= line;
      do @(posedge clock); while (req_stall !== 1'b0);
      predicted = advance_receiver(line);
      pending_rx_results.push_back(typed ? want : predicted);
      ticks_sent++;
   endtask

   task automatic line_tick(input logic lvl);
      send_tick('{rx_level: lvl, read_request: ($urandom_range(0, 99) < read_pct)},
                1'b0, '0);
   endtask

   // Drop valid and hold until every outstanding result has come back.
   task automatic wait_for_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_rx_results.size() != 0);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      wait_for_results();
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_write <= 1'b0;
      case (idx)
         CSR_RX_ENABLE:    cfg.rx_enable          = value[0];
         CSR_CENTER_DELAY: cfg.center_delay_ticks = value;
         CSR_BIT_DELAY:    cfg.bit_delay_ticks    = value;
         default:          cfg.stop_delay_ticks   = value;
      endcase
   endtask

   task automatic set_config(input logic en, input logic [DELAY_W-1:0] center,
                             input logic [DELAY_W-1:0] bit_gap,
                             input logic [DELAY_W-1:0] stop);
      write_reg(CSR_RX_ENABLE, CSR_DATA_W'(en));
      write_reg(CSR_CENTER_DELAY, center);
      write_reg(CSR_BIT_DELAY, bit_gap);
      write_reg(CSR_STOP_DELAY, stop);
   endtask

   // Drive one 8N1 frame on the line, timed to the current delays. Past the
   // cut offset the line goes random, which can break the frame.
   task automatic send_frame(input logic [7:0] data, input int cut);
      int   c;
      int   b;
      int   span;
      int   o;
      logic lvl;
      // hold the line high until the receiver is re-armed
      while (rx_phase != RX_IDLE || !prev_level) line_tick(1'b1);
      c    = (cfg.center_delay_ticks == 0) ? 1 : int'(cfg.center_delay_ticks);
      b    = (cfg.bit_delay_ticks == 0) ? 1 : int'(cfg.bit_delay_ticks);
      span = c + 8 * b;
      for (o = 0; o <= span; o++) begin
         if (o > cut) lvl = 1'($urandom_range(0, 1));
         else if (o <= c) lvl = 1'b0;
         else lvl = data[(o - c - 1) / b];
         line_tick(lvl);
      end
      while (rx_phase != RX_IDLE) line_tick(1'b1);
   endtask

   // Result side: compare every accepted transaction with the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (pending_rx_results.size() == 0) begin
            mismatch_count++;
            $display("%0t: result expected none, got %h", $time, rsp_payload);
         end else begin
            want_rsp = pending_rx_results.pop_front();
            check_field("read_data", want_rsp.read_data, rsp_payload.read_data);
            check_field("read_valid", 8'(want_rsp.read_valid),
                        8'(rsp_payload.read_valid));
            check_field("fill_count", 8'(want_rsp.fill_count),
                        8'(rsp_payload.fill_count));
            check_field("overflow_flag", 8'(want_rsp.overflow_flag),
                        8'(rsp_payload.overflow_flag));
            check_field("frame_busy", 8'(want_rsp.frame_busy),
                        8'(rsp_payload.frame_busy));
         end
      end
   end

   // Receiver back-pressure: random stalls, off while idle_en is low.
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (idle_en && $urandom_range(0, 99) < 20) begin
            rsp_stall <= 1'b1;
            repeat (gap_len()) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      #20_000_000;
      $display("tb_top failed");
      $finish;
   end

   initial begin : stimulus
      int           i;
      int           pick;
      stim_row_type row;

      reset       = 1'b1;
      req_valid   = 1'b0;
      req_payload = '0;
      csr_write   = 1'b0;
      csr_index   = '0;
      csr_wdata   = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed table: reset state, zero delays, both byte extremes,
      // disabled reads and a frame that outlives its enable.
      for (i = 0; i < DIRECTED_ROWS; i++) begin
         row = DIRECTED_STIM[i];
         if (row.kind == ROW_CSR) write_reg(row.reg_idx, row.reg_data);
         else send_tick(row.line, row.typed, row.want);
      end

      // Flood the FIFO with no reads: fill it to the brim and overflow it.
      set_config(1'b1, DELAY_W'($urandom_range(0, 1)), DELAY_W'($urandom_range(0, 1)),
                 DELAY_W'($urandom_range(0, 1)));
      read_pct = 0;
      repeat (FIFO_DEPTH_DEFAULT + 2)
         send_frame(8'($urandom_range(0, 255)), WHOLE_FRAME);
      // hold the sender until the block has answered every tick
      wait_for_results();

      // Random part: mostly clean frames, some broken ones, noise and read runs.
      read_pct = 40;
      while (ticks_sent < 1100) begin
         pick = $urandom_range(0, 99);
         if (pick < 12) begin
            set_config($urandom_range(0, 9) != 0, rand_delay(), rand_delay(), rand_delay());
            read_pct = $urandom_range(0, 100);
            idle_en  = ($urandom_range(0, 3) != 0);
         end else if (pick < 72) begin
            send_frame(8'($urandom_range(0, 255)), WHOLE_FRAME);
         end else if (pick < 82) begin
            send_frame(8'($urandom_range(0, 255)), $urandom_range(0, 30));
         end else if (pick < 92) begin
            repeat ($urandom_range(1, 20)) line_tick(1'($urandom_range(0, 1)));
         end else begin
            repeat ($urandom_range(1, 70)) send_tick('{1'b1, 1'b1}, 1'b0, '0);
         end
      end

      // Drain, then give the pipeline time to show any stray result.
      wait_for_results();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0) $display("tb_top passed");
      else $display("tb_top failed");
      $finish;
   end

endmodule

FILE: sim.f
+incdir+rtl
rtl/uartrx_pkg.sv
rtl/uartrx_ram.sv
rtl/uartrx_front.sv
rtl/uartrx_queue.sv
rtl/uartrx_back.sv
rtl/uart_receiver_with_rx_fifo.sv
rtl/uartrx_checker.sv
dv/tb_top.sv
